>>> sv/bpa_pkg.sv
// Shared types, constants and codes for the buddy page allocator.
package bpa_pkg;

    localparam int MAX_ORDER  = 10;
    localparam int ZONE_PAGES = 4096;
    localparam int HEADS      = MAX_ORDER + 1;
    localparam int ORD_W      = 4;
    localparam int PAGE_W     = 12;
    localparam int LINK_W     = 13;
    localparam int CNT_W      = 13;
    localparam int ZFP_W      = 36;
    localparam int INFO_W     = ORD_W + 1;

    localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(ZONE_PAGES);
    localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
    localparam logic              FREE_MARK = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOBLK  = 2'd1;
    localparam logic [1:0] ST_BADORD = 2'd2;

    // item kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // configuration register indexes
    localparam logic REG_ZONE_FIRST_PAGE = 1'b0;
    localparam logic REG_ZONE_PAGES      = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [ORD_W-1:0]  block_order;
        logic [PAGE_W-1:0] page_index;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [PAGE_W-1:0] block_page;
        logic [CNT_W-1:0]  free_pages;
    } t_out;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DISP, S_AUNL, S_ASPL,
        S_FCHK, S_FTST, S_PUSH1, S_PUSH2, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLR, OP_LOAD, OP_RES_ERR, OP_NOBLK, OP_FIND, OP_UNLINK,
        OP_SPLIT, OP_ALLOC_END, OP_FIGN, OP_FCHK, OP_FMERGE, OP_FPREP,
        OP_PUSH1, OP_PUSH2, OP_OUT
    } t_op;

    typedef struct packed {
        logic bad_order;
        logic is_free;
        logic found;
        logic ignore;
        logic k_gt_ord;
        logic k_lt_max;
        logic bud_ok;
        logic merge_ok;
        logic clr_done;
        logic out_free;
    } t_stat;

endpackage

>>> sv/buddy_page_allocator_core.sv
// Binary buddy page allocator for one zone: top level.
//
// Input channel i_in (kind, block_order, page_index) with i_in_valid and
// o_in_stall; a transaction is taken at an edge with valid high and stall low.
// Result channel o_out (status, block_page, free_pages) with o_out_valid and
// i_out_stall; one result per input transaction, in order.
// Config port: i_cfg_we, i_cfg_idx (0 zone first page, 1 zone pages),
// i_cfg_data; write only while the block is idle.
// One transaction at a time through a sequencer over three page RAMs (page
// info, next link, prev link).
// An order error, an empty search or an ignored free goes straight to the result;
// an allocate unlinks the found block and splits it a level at a time, pushing
// each buddy inside the zone; a free merges up level by level, then pushes.
// The next transaction can be accepted in the cycle after the result is loaded.
// After reset the page info RAM is cleared with o_in_stall high.
// A finished result sits in an output register; the next transaction is taken
// while it waits, and the following one waits until the slot frees up.
module buddy_page_allocator_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bpa_pkg::t_in              i_in,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    output bpa_pkg::t_out             o_out,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [bpa_pkg::ZFP_W-1:0] i_cfg_data
);

    bpa_pkg::t_op   op;
    bpa_pkg::t_stat stat;

    // sequencer
    bpa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_stat(stat), .o_op(op), .o_in_stall(o_in_stall));

    // datapath
    bpa_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(op), .o_stat(stat), .i_in(i_in),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_out(o_out), .o_out_valid(o_out_valid), .i_out_stall(i_out_stall));

endmodule

>>> sv/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bpa_ctrl.sv
// Sequencer for allocate, free, split, merge and list push steps.
module bpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  bpa_pkg::t_stat i_stat,
    output bpa_pkg::t_op  o_op,
    output logic          o_in_stall
);

    bpa_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpa_pkg::S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bpa_pkg::S_CLR:   if (i_stat.clr_done) n_state = bpa_pkg::S_IDLE;
            bpa_pkg::S_IDLE:  if (i_in_valid) n_state = bpa_pkg::S_DISP;
            bpa_pkg::S_DISP: begin
                if (i_stat.bad_order) n_state = bpa_pkg::S_DONE;
                else if (!i_stat.is_free) begin
                    n_state = i_stat.found ? bpa_pkg::S_AUNL : bpa_pkg::S_DONE;
                end else begin
                    n_state = i_stat.ignore ? bpa_pkg::S_DONE : bpa_pkg::S_FCHK;
                end
            end
            bpa_pkg::S_AUNL:  n_state = bpa_pkg::S_ASPL;
            bpa_pkg::S_ASPL: begin
                if (i_stat.k_gt_ord) begin
                    n_state = i_stat.bud_ok ? bpa_pkg::S_PUSH1 : bpa_pkg::S_ASPL;
                end else begin
                    n_state = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_FCHK: begin
                n_state = (i_stat.k_lt_max && i_stat.bud_ok) ? bpa_pkg::S_FTST
                                                             : bpa_pkg::S_PUSH1;
            end
            bpa_pkg::S_FTST: begin
                n_state = i_stat.merge_ok ? bpa_pkg::S_FCHK : bpa_pkg::S_PUSH1;
            end
            bpa_pkg::S_PUSH1: n_state = bpa_pkg::S_PUSH2;
            bpa_pkg::S_PUSH2: n_state = i_stat.is_free ? bpa_pkg::S_DONE : bpa_pkg::S_ASPL;
            bpa_pkg::S_DONE:  if (i_stat.out_free) n_state = bpa_pkg::S_IDLE;
            default:          n_state = bpa_pkg::S_IDLE;
        endcase
    end

    // datapath command per state
    always_comb begin
        o_op = bpa_pkg::OP_NONE;
        case (r_state)
            bpa_pkg::S_CLR:   if (!i_stat.clr_done) o_op = bpa_pkg::OP_CLR;
            bpa_pkg::S_IDLE:  if (i_in_valid) o_op = bpa_pkg::OP_LOAD;
            bpa_pkg::S_DISP: begin
                if (i_stat.bad_order) o_op = bpa_pkg::OP_RES_ERR;
                else if (!i_stat.is_free) begin
                    o_op = i_stat.found ? bpa_pkg::OP_FIND : bpa_pkg::OP_NOBLK;
                end else begin
                    o_op = i_stat.ignore ? bpa_pkg::OP_FIGN : bpa_pkg::OP_NONE;
                end
            end
            bpa_pkg::S_AUNL:  o_op = bpa_pkg::OP_UNLINK;
            bpa_pkg::S_ASPL: begin
                o_op = i_stat.k_gt_ord ? bpa_pkg::OP_SPLIT : bpa_pkg::OP_ALLOC_END;
            end
            bpa_pkg::S_FCHK: begin
                o_op = (i_stat.k_lt_max && i_stat.bud_ok) ? bpa_pkg::OP_FCHK
                                                          : bpa_pkg::OP_FPREP;
            end
            bpa_pkg::S_FTST: begin
                o_op = i_stat.merge_ok ? bpa_pkg::OP_FMERGE : bpa_pkg::OP_FPREP;
            end
            bpa_pkg::S_PUSH1: o_op = bpa_pkg::OP_PUSH1;
            bpa_pkg::S_PUSH2: o_op = bpa_pkg::OP_PUSH2;
            bpa_pkg::S_DONE:  if (i_stat.out_free) o_op = bpa_pkg::OP_OUT;
            default:          o_op = bpa_pkg::OP_NONE;
        endcase
    end

    assign o_in_stall = (r_state != bpa_pkg::S_IDLE);

    // buddy test uses RAM data read in the check step
    a_tst_after_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bpa_pkg::S_FTST |-> $past(r_state) == bpa_pkg::S_FCHK)
        else $error("merge test without a preceding buddy read");

    // no transaction enters while the page info is being cleared
    a_clr_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bpa_pkg::S_CLR |=> r_state == bpa_pkg::S_CLR || r_state == bpa_pkg::S_IDLE)
        else $error("left clearing pass early");

    // a push pair always runs back to back
    a_push_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bpa_pkg::S_PUSH2 |-> $past(r_state) == bpa_pkg::S_PUSH1)
        else $error("list head update without link write");

endmodule

>>> sv/bpa_dp.sv
// Datapath: list heads, page info and link RAMs, buddy math, counters, result.
module bpa_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bpa_pkg::t_op              i_op,
    output bpa_pkg::t_stat            o_stat,
    input  bpa_pkg::t_in              i_in,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [bpa_pkg::ZFP_W-1:0] i_cfg_data,
    output bpa_pkg::t_out             o_out,
    output logic                      o_out_valid,
    input  logic                      i_out_stall
);

    localparam int PW = bpa_pkg::PAGE_W;
    localparam int LW = bpa_pkg::LINK_W;
    localparam int OW = bpa_pkg::ORD_W;
    localparam int ZW = bpa_pkg::ZFP_W;
    localparam int CW = bpa_pkg::CNT_W;
    localparam int IW = bpa_pkg::INFO_W;

    // configuration
    logic [ZW-1:0] r_zfp;
    logic [CW-1:0] r_zpages;

    // item context; absolute pages carry one extra bit so base + page never wraps
    logic          r_kind;
    logic [OW-1:0] r_ord;
    logic [OW-1:0] r_k;
    logic [PW-1:0] r_cur;
    logic [ZW:0]   r_abs;
    logic [PW-1:0] r_pp;
    logic [ZW:0]   r_babs;
    logic [1:0]    r_st;
    logic [PW-1:0] r_bp;

    // control state
    logic [LW-1:0] r_head [bpa_pkg::HEADS];
    logic [CW-1:0] r_cnt;
    logic [PW:0]   r_clr;
    logic          r_out_valid;
    bpa_pkg::t_out r_out;

    // RAM ports
    logic          info_we, next_we, prev_we;
    logic [PW-1:0] info_wa, next_wa, prev_wa, rd_addr;
    logic [IW-1:0] info_wd, rd_info;
    logic [LW-1:0] next_wd, prev_wd, rd_next, rd_prev;

    bpa_ram #(.WIDTH(IW), .DEPTH(bpa_pkg::ZONE_PAGES)) u_info (
        .i_clk(i_clk), .i_we(info_we), .i_waddr(info_wa), .i_wdata(info_wd),
        .i_raddr(rd_addr), .o_rdata(rd_info));
    bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::ZONE_PAGES)) u_next (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_wa), .i_wdata(next_wd),
        .i_raddr(rd_addr), .o_rdata(rd_next));
    bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::ZONE_PAGES)) u_prev (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_wa), .i_wdata(prev_wd),
        .i_raddr(rd_addr), .o_rdata(rd_prev));

    // usable pages and block size
    logic [CW-1:0] eff, size13, idx13;
    logic [10:0]   amask;
    assign eff    = (r_zpages < CW'(bpa_pkg::ZONE_PAGES)) ? r_zpages
                                                           : CW'(bpa_pkg::ZONE_PAGES);
    assign size13 = CW'(1) << r_ord;
    assign idx13  = {1'b0, r_cur};
    assign amask  = 11'(size13 - CW'(1));

    // buddy address: split uses order k-1, merge uses order k
    logic [OW-1:0] bit_idx;
    logic [ZW:0]   babs;
    logic [ZW+1:0] bdiff;
    logic [CW-1:0] blim;
    logic          bud_ok;
    logic [PW-1:0] b_page;
    assign bit_idx = (r_kind == bpa_pkg::KIND_ALLOC) ? r_k - OW'(1) : r_k;
    assign babs    = r_abs ^ ((ZW+1)'(1) << bit_idx);
    assign bdiff   = {1'b0, babs} - {2'b00, r_zfp};
    assign blim    = (r_kind == bpa_pkg::KIND_FREE) ? eff : CW'(bpa_pkg::ZONE_PAGES);
    assign bud_ok  = !bdiff[ZW+1] && (bdiff[ZW:0] < (ZW+1)'(blim));
    assign b_page  = bdiff[PW-1:0];

    // head of the current order
    logic [LW-1:0] head_k;
    assign head_k = (r_k <= OW'(bpa_pkg::MAX_ORDER)) ? r_head[r_k] : bpa_pkg::NIL_LINK;

    // first non-empty list at or above the requested order
    logic          found;
    logic [OW-1:0] find_f;
    logic [PW-1:0] find_p;
    always_comb begin
        found  = 1'b0;
        find_f = '0;
        find_p = '0;
        for (int f = bpa_pkg::MAX_ORDER; f >= 0; f--) begin
            if (OW'(f) >= r_ord && !r_head[f][LW-1]) begin
                found  = 1'b1;
                find_f = OW'(f);
                find_p = r_head[f][PW-1:0];
            end
        end
    end

    // saturating count updates
    logic [CW:0]   cnt_sum;
    logic [CW-1:0] cnt_add, cnt_sub;
    assign cnt_sum = {1'b0, r_cnt} + {1'b0, size13};
    assign cnt_add = (cnt_sum > {1'b0, bpa_pkg::COUNT_MAX}) ? bpa_pkg::COUNT_MAX
                                                             : cnt_sum[CW-1:0];
    assign cnt_sub = (r_cnt > size13) ? r_cnt - size13 : '0;

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    // status to the sequencer
    always_comb begin
        o_stat.bad_order = (r_ord > OW'(bpa_pkg::MAX_ORDER));
        o_stat.is_free   = (r_kind == bpa_pkg::KIND_FREE);
        o_stat.found     = found;
        o_stat.ignore    = ((r_abs[10:0] & amask) != '0) || (idx13 >= eff)
                           || (idx13 + size13 > eff);
        o_stat.k_gt_ord  = (r_k > r_ord);
        o_stat.k_lt_max  = (r_k < OW'(bpa_pkg::MAX_ORDER));
        o_stat.bud_ok    = bud_ok;
        o_stat.merge_ok  = (rd_info[IW-1:1] == r_k) && (rd_info[0] == bpa_pkg::FREE_MARK);
        o_stat.clr_done  = r_clr[PW];
        o_stat.out_free  = out_free;
    end

    // RAM write and read address selection
    always_comb begin
        info_we = 1'b0; info_wa = r_pp; info_wd = '0;
        next_we = 1'b0; next_wa = rd_prev[PW-1:0]; next_wd = rd_next;
        prev_we = 1'b0; prev_wa = rd_next[PW-1:0]; prev_wd = rd_prev;
        rd_addr = b_page;
        case (i_op)
            bpa_pkg::OP_CLR: begin
                info_we = 1'b1;
                info_wa = r_clr[PW-1:0];
            end
            bpa_pkg::OP_FIND: rd_addr = find_p;
            bpa_pkg::OP_UNLINK: begin
                next_we = !rd_prev[LW-1];
                prev_we = !rd_next[LW-1];
            end
            bpa_pkg::OP_FMERGE: begin
                next_we = !rd_prev[LW-1];
                prev_we = !rd_next[LW-1];
                info_we = 1'b1;
                info_wd = {r_k, 1'b0};
            end
            bpa_pkg::OP_ALLOC_END: begin
                info_we = 1'b1;
                info_wa = r_cur;
                info_wd = {r_ord, 1'b0};
            end
            bpa_pkg::OP_PUSH1: begin
                info_we = 1'b1;
                info_wd = {r_k, bpa_pkg::FREE_MARK};
                next_we = 1'b1;
                next_wa = r_pp;
                next_wd = head_k;
                prev_we = 1'b1;
                prev_wa = r_pp;
                prev_wd = bpa_pkg::NIL_LINK;
            end
            bpa_pkg::OP_PUSH2: begin
                prev_we = !head_k[LW-1];
                prev_wa = head_k[PW-1:0];
                prev_wd = {1'b0, r_pp};
            end
            default: ;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zfp    <= '0;
            r_zpages <= CW'(bpa_pkg::ZONE_PAGES);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == bpa_pkg::REG_ZONE_FIRST_PAGE) r_zfp <= i_cfg_data;
            else r_zpages <= i_cfg_data[CW-1:0];
        end
    end

    // list heads, free count, clear counter, result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bpa_pkg::HEADS; i++) r_head[i] <= bpa_pkg::NIL_LINK;
            r_cnt       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_op == bpa_pkg::OP_OUT) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (i_op)
                bpa_pkg::OP_CLR: r_clr <= r_clr + (PW+1)'(1);
                bpa_pkg::OP_UNLINK: begin
                    if (rd_prev[LW-1] && r_k <= OW'(bpa_pkg::MAX_ORDER)) r_head[r_k] <= rd_next;
                    r_cnt <= cnt_sub;
                end
                bpa_pkg::OP_FMERGE: begin
                    if (rd_prev[LW-1] && r_k <= OW'(bpa_pkg::MAX_ORDER)) r_head[r_k] <= rd_next;
                end
                bpa_pkg::OP_PUSH2: begin
                    if (r_k <= OW'(bpa_pkg::MAX_ORDER)) r_head[r_k] <= {1'b0, r_pp};
                    if (r_kind == bpa_pkg::KIND_FREE) r_cnt <= cnt_add;
                end
                default: ;
            endcase
        end
    end

    // item context and result payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            bpa_pkg::OP_LOAD: begin
                r_kind <= i_in.kind;
                r_ord  <= i_in.block_order;
                r_k    <= i_in.block_order;
                r_cur  <= i_in.page_index;
                r_abs  <= {1'b0, r_zfp} + (ZW+1)'(i_in.page_index);
            end
            bpa_pkg::OP_RES_ERR: begin
                r_st <= bpa_pkg::ST_BADORD;
                r_bp <= '0;
            end
            bpa_pkg::OP_NOBLK: begin
                r_st <= bpa_pkg::ST_NOBLK;
                r_bp <= '0;
            end
            bpa_pkg::OP_FIND: begin
                r_k   <= find_f;
                r_cur <= find_p;
                r_abs <= {1'b0, r_zfp} + (ZW+1)'(find_p);
            end
            bpa_pkg::OP_SPLIT: begin
                r_pp <= b_page;
                r_k  <= r_k - OW'(1);
            end
            bpa_pkg::OP_ALLOC_END: begin
                r_st <= bpa_pkg::ST_OK;
                r_bp <= r_cur;
            end
            bpa_pkg::OP_FIGN: begin
                r_st <= bpa_pkg::ST_OK;
                r_bp <= '0;
            end
            bpa_pkg::OP_FCHK: begin
                r_pp   <= b_page;
                r_babs <= babs;
            end
            bpa_pkg::OP_FMERGE: begin
                r_k <= r_k + OW'(1);
                if (r_pp < r_cur) begin
                    r_cur <= r_pp;
                    r_abs <= r_babs;
                end
            end
            bpa_pkg::OP_FPREP: r_pp <= r_cur;
            bpa_pkg::OP_PUSH2: begin
                if (r_kind == bpa_pkg::KIND_FREE) begin
                    r_st <= bpa_pkg::ST_OK;
                    r_bp <= '0;
                end
            end
            bpa_pkg::OP_OUT: r_out <= '{status: r_st, block_page: r_bp, free_pages: r_cnt};
            default: ;
        endcase
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    // result slot is only loaded when it is empty or draining
    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == bpa_pkg::OP_OUT |-> out_free)
        else $error("result overwritten while stalled");

    // failed transactions carry page zero
    a_fail_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != bpa_pkg::ST_OK |-> r_out.block_page == '0)
        else $error("failure result with nonzero page");

    // RAM clear finishes before any free list is touched
    a_clear_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == bpa_pkg::OP_PUSH1 |-> r_clr[PW])
        else $error("list push during clearing pass");

endmodule

>>> verif/tb_buddy_page_allocator_core.sv
// Self-checking testbench for the buddy page allocator core.
module tb_buddy_page_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;
    import bpa_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    t_in                  i_in;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_out                 o_out;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 i_cfg_we;
    logic                 i_cfg_idx;
    logic [ZFP_W-1:0]     i_cfg_data;

    buddy_page_allocator_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .o_out(o_out), .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // allocator shadow state
    logic [ZFP_W-1:0]  zone_base;
    logic [CNT_W-1:0]  zone_len;
    logic [ORD_W-1:0]  pg_order [ZONE_PAGES];
    logic              pg_free  [ZONE_PAGES];
    logic [LINK_W-1:0] nxt      [ZONE_PAGES];
    logic [LINK_W-1:0] prv      [ZONE_PAGES];
    logic [LINK_W-1:0] head     [HEADS];
    logic [CNT_W-1:0]  avail;

    t_out expected_results [$];
    int   errors;
    bit   quiet_mode;     // no idling on either side
    int   owned_page [$]; // blocks handed out, for well-formed frees
    int   owned_ord  [$];

    function automatic void shadow_reset();
        for (int i = 0; i < ZONE_PAGES; i++) begin
            pg_order[i] = '0;
            pg_free[i]  = 1'b0;
            nxt[i]      = '0;
            prv[i]      = '0;
        end
        for (int i = 0; i < HEADS; i++) head[i] = NIL_LINK;
        avail = '0;
        zone_base = '0;
        zone_len = CNT_W'(4096);
    endfunction

    function automatic void list_push(int ord, int p);
        logic [LINK_W-1:0] n;
        n = head[ord];
        nxt[p] = n;
        prv[p] = NIL_LINK;
        if (n < ZONE_PAGES) prv[n] = LINK_W'(p);
        head[ord] = LINK_W'(p);
    endfunction

    function automatic void list_unlink(int ord, int p);
        logic [LINK_W-1:0] pr, nx;
        pr = prv[p];
        nx = nxt[p];
        if (pr < ZONE_PAGES) nxt[pr] = nx;
        else head[ord] = nx;
        if (nx < ZONE_PAGES) prv[nx] = pr;
    endfunction

    function automatic void count_up(int n);
        int s;
        s = int'(avail) + n;
        avail = (s > 8191) ? COUNT_MAX : CNT_W'(s);
    endfunction

    // computes the result of one transaction and updates the shadow state
    function automatic t_out allocator_step(t_in it);
        t_out r;
        int ord, p, found;
        longint unsigned babs, b, eff, size, cur, k, base;
        r = '0;
        ord = it.block_order;
        base = zone_base;
        if (ord > MAX_ORDER) begin
            r.status = ST_BADORD;
        end else if (it.kind == KIND_ALLOC) begin
            found = 0;
            r.status = ST_NOBLK;
            for (int f = ord; f <= MAX_ORDER && !found; f++) begin
                p = head[f];
                if (p < ZONE_PAGES) begin
                    found = 1;
                    list_unlink(f, p);
                    avail = (int'(avail) > (1 << ord)) ? avail - CNT_W'(1 << ord) : '0;
                    for (int kk = f; kk > ord; kk--) begin
                        babs = (base + p) ^ (64'd1 << (kk - 1));
                        b = babs - base;
                        if (!(babs < base || b >= ZONE_PAGES)) begin
                            pg_order[b] = ORD_W'(kk - 1);
                            pg_free[b] = FREE_MARK;
                            list_push(kk - 1, int'(b));
                        end
                    end
                    pg_order[p] = ORD_W'(ord);
                    pg_free[p] = 1'b0;
                    r.status = ST_OK;
                    r.block_page = PAGE_W'(p);
                end
            end
        end else begin
            eff = (zone_len < ZONE_PAGES) ? zone_len : ZONE_PAGES;
            size = 64'd1 << ord;
            cur = it.page_index;
            k = ord;
            if (((base + cur) & (size - 1)) == 0 && cur < eff && cur + size <= eff) begin
                while (k < MAX_ORDER) begin
                    babs = (base + cur) ^ (64'd1 << k);
                    if (babs < base) break;
                    b = babs - base;
                    if (b >= eff) break;
                    if (pg_order[b] != k || !pg_free[b]) break;
                    list_unlink(int'(k), int'(b));
                    pg_free[b] = 1'b0;
                    k++;
                    if (b < cur) cur = b;
                end
                pg_order[cur] = ORD_W'(k);
                pg_free[cur] = FREE_MARK;
                list_push(int'(k), int'(cur));
                count_up(int'(size));
            end
        end
        r.free_pages = avail;
        return r;
    endfunction

    function automatic bit idle_now();
        return !quiet_mode && ($urandom_range(99) < 36);
    endfunction

    // send one transaction and queue its expected result
    task automatic send_item(logic kind, logic [ORD_W-1:0] ord, logic [PAGE_W-1:0] pg);
        t_in it;
        while (idle_now()) @(negedge i_clk);
        it.kind = kind;
        it.block_order = ord;
        it.page_index = pg;
        i_in = it;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(allocator_step(it));
        if (kind == KIND_ALLOC && expected_results[$].status == ST_OK) begin
            owned_page.push_back(expected_results[$].block_page);
            owned_ord.push_back(ord);
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain();
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [ZFP_W-1:0] val);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_ZONE_FIRST_PAGE) zone_base = val;
        else zone_len = val[CNT_W-1:0];
    endtask

    // free one previously allocated block, chosen at random
    task automatic free_owned();
        int j, p, o;
        j = $urandom_range(owned_page.size() - 1);
        p = owned_page[j];
        o = owned_ord[j];
        owned_page.delete(j);
        owned_ord.delete(j);
        send_item(KIND_FREE, ORD_W'(o), PAGE_W'(p));
    endtask

    // free the first n pages of the zone with order-0 frees
    task automatic populate(int n);
        for (int i = 0; i < n; i++) send_item(KIND_FREE, '0, PAGE_W'(i));
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result without a pending transaction");
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_out.status != e.status) begin
                    $error("status exp %0d got %0d", e.status, o_out.status); errors++;
                end
                if (o_out.block_page != e.block_page) begin
                    $error("block_page exp %0d got %0d", e.block_page, o_out.block_page);
                    errors++;
                end
                if (o_out.free_pages != e.free_pages) begin
                    $error("free_pages exp %0d got %0d", e.free_pages, o_out.free_pages);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) i_out_stall <= i_rst_n ? idle_now() : 1'b0;

    task automatic test_directed();
        send_item(KIND_ALLOC, '0, '0);              // empty store
        send_item(KIND_ALLOC, 4'd15, 12'hFFF);      // order too large
        send_item(KIND_FREE, 4'd11, '0);
        send_item(KIND_FREE, 4'd10, 12'd0);         // whole aligned block
        send_item(KIND_FREE, 4'd10, 12'd1024);
        send_item(KIND_FREE, 4'd3, 12'd5);          // misaligned, ignored
        send_item(KIND_ALLOC, 4'd0, '0);            // split all the way
        send_item(KIND_ALLOC, 4'd10, '0);
        send_item(KIND_ALLOC, 4'd10, '0);
        send_item(KIND_FREE, 4'd0, 12'd0);          // page 0 freed at order 0, buddy not free
        send_item(KIND_FREE, 4'd0, 12'd0);          // double free
        send_item(KIND_FREE, 4'd10, 12'd3072);
        send_item(KIND_FREE, 4'd0, 12'hFFF);        // top page
        send_item(KIND_ALLOC, 4'd5, 12'hABC);
    endtask

    task automatic test_random(int n);
        int c;
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(99);
            if (c < 45) send_item(KIND_ALLOC, ORD_W'($urandom_range(4)), PAGE_W'($urandom));
            else if (c < 85 && owned_page.size() != 0) free_owned();
            else if (c < 92) send_item(KIND_FREE, ORD_W'($urandom_range(10)), PAGE_W'($urandom));
            else send_item(KIND_ALLOC, ORD_W'($urandom), PAGE_W'($urandom));
        end
    endtask

    // run one random phase under a given zone setting
    task automatic test_zone(logic [ZFP_W-1:0] base, int len, int n);
        write_reg(REG_ZONE_FIRST_PAGE, base);
        write_reg(REG_ZONE_PAGES, ZFP_W'(len));
        drain();
        owned_page.delete();
        owned_ord.delete();
        populate((len < 64) ? len : 64);
        test_random(n);
    endtask

    task automatic test_quiet_stretch();
        quiet_mode = 1'b1;
        test_random(120);
        drain();
        quiet_mode = 1'b0;
    endtask

    initial begin
        errors = 0;
        quiet_mode = 1'b0;
        shadow_reset();
        i_rst_n = 1'b0;
        i_in = '0;
        i_in_valid = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_ZONE_FIRST_PAGE;
        i_cfg_data = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(100);
        drain();                                   // sender waits for all results
        test_quiet_stretch();
        test_zone(ZFP_W'(3), 4096, 180);
        test_zone(ZFP_W'(36'hFFFFFFFFF), 1, 40);
        test_zone(ZFP_W'(512), 8191, 150);
        test_zone(ZFP_W'($urandom), 100, 150);
        test_zone(ZFP_W'(0), 2048, 150);
        drain();
        if (errors == 0 && expected_results.size() == 0)
            $display("buddy_page_allocator_core verification clean");
        else
            $display("buddy_page_allocator_core verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("buddy_page_allocator_core verification failed");
        $finish;
    end
endmodule
